// ----- sv/pwcd_pkg.sv -----
// ----------------------------------------------------------------------------
// pwcd_pkg
// Shared types and constants for the pulse width code decoder.
// ----------------------------------------------------------------------------
package pwcd_pkg;

  localparam int DURATION_BITS_DEF = 20;
  localparam int CODE_BITS_DEF     = 32;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [5:0] HEADER_UNITS = 6'd35;
  localparam int         GAP_SHIFT    = 2;      // frame gap is at least four short units
  localparam logic [1:0] BUTTON_MASK  = 2'b11;

  localparam logic [15:0] SHORT_UNIT_RST = 16'd555;
  localparam logic [15:0] LONG_UNIT_RST  = 16'd1111;
  localparam logic [15:0] TOLERANCE_RST  = 16'd120;
  localparam logic [7:0]  MIN_BITS_RST   = 8'd12;

  typedef enum logic [1:0] {
    REG_SHORT_UNIT = 2'd0,
    REG_LONG_UNIT  = 2'd1,
    REG_TOLERANCE  = 2'd2,
    REG_MIN_BITS   = 2'd3
  } pwcd_reg_t;

  typedef struct packed {
    logic [15:0] short_unit_us;
    logic [15:0] long_unit_us;
    logic [15:0] tolerance_us;
    logic [7:0]  min_bits;
  } pwcd_cfg_t;

  // classification of one pulse, as handed from front to back
  typedef struct packed {
    logic is_high;
    logic hdr_match;
    logic near_short;
    logic near_long;
    logic gap;
  } pwcd_cls_t;

endpackage

// ----- sv/pwcd_front.sv -----
// ----------------------------------------------------------------------------
// pwcd_front
// Classifies one pulse against the programmed nominal durations.
// ----------------------------------------------------------------------------
module pwcd_front #(
  parameter int DURATION_BITS = pwcd_pkg::DURATION_BITS_DEF
) (
  input  pwcd_pkg::pwcd_cfg_t     cfg,
  input  logic                    pulse_level,
  input  logic [DURATION_BITS-1:0] pulse_us,
  output pwcd_pkg::pwcd_cls_t     cls
);

  // wide enough for the duration and for 35 times a 16-bit unit
  localparam int CW = ((DURATION_BITS > 22) ? DURATION_BITS : 22) + 1;

  logic [CW-1:0] d_ext;
  logic [CW-1:0] short_ext;
  logic [CW-1:0] long_ext;
  logic [CW-1:0] tol_ext;
  logic [CW-1:0] hdr_nom;
  logic [CW-1:0] hdr_tol;
  logic [CW-1:0] gap_min;
  logic [CW-1:0] diff_hdr;
  logic [CW-1:0] diff_short;
  logic [CW-1:0] diff_long;

  assign d_ext     = CW'(pulse_us);
  assign short_ext = CW'(cfg.short_unit_us);
  assign long_ext  = CW'(cfg.long_unit_us);
  assign tol_ext   = CW'(cfg.tolerance_us);
  assign hdr_nom   = short_ext * CW'(pwcd_pkg::HEADER_UNITS);
  assign hdr_tol   = tol_ext * CW'(pwcd_pkg::HEADER_UNITS);
  assign gap_min   = short_ext << pwcd_pkg::GAP_SHIFT;

  assign diff_hdr   = (d_ext > hdr_nom)   ? d_ext - hdr_nom   : hdr_nom - d_ext;
  assign diff_short = (d_ext > short_ext) ? d_ext - short_ext : short_ext - d_ext;
  assign diff_long  = (d_ext > long_ext)  ? d_ext - long_ext  : long_ext - d_ext;

  always_comb begin
    cls.is_high    = pulse_level;
    cls.hdr_match  = diff_hdr < hdr_tol;
    cls.near_short = diff_short < tol_ext;
    cls.near_long  = diff_long < tol_ext;
    cls.gap        = d_ext >= gap_min;
  end

endmodule

// ----- sv/pwcd_queue.sv -----
// ----------------------------------------------------------------------------
// pwcd_queue
// Short queue of classified pulses between the front and the back.
// ----------------------------------------------------------------------------
module pwcd_queue #(
  parameter int DEPTH = pwcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  pwcd_pkg::pwcd_cls_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output logic                rd_valid,
  output pwcd_pkg::pwcd_cls_t rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH+1);

  pwcd_pkg::pwcd_cls_t mem_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full     = (count_r == CNTW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign count    = count_r;
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    count_nxt = count_r;
    if (do_wr) begin
      wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNTW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ----- sv/pwcd_back.sv -----
// ----------------------------------------------------------------------------
// pwcd_back
// Frame state machine: header, start pulse, bit pairs, frame end and result.
// ----------------------------------------------------------------------------
module pwcd_back #(
  parameter int CODE_BITS = pwcd_pkg::CODE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pwcd_pkg::pwcd_cfg_t cfg,
  input  logic                q_valid,
  input  pwcd_pkg::pwcd_cls_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_code_word,
  output logic [7:0]          out_bit_total,
  output logic [1:0]          out_button_bits
);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_START  = 4'b0010,
    PH_LOW    = 4'b0100,
    PH_HIGH   = 4'b1000
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [CODE_BITS-1:0] shift_r, shift_nxt;
  logic [7:0]           bits_r, bits_nxt;
  logic                 held_short_r, held_short_nxt;
  logic                 held_long_r, held_long_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          code_r;
  logic [7:0]           total_r;
  logic [1:0]           button_r;
  logic                 emit;
  logic                 push;
  logic                 push_bit;
  logic [31:0]          code_now;

  // back moves on unless a finished result is held under stall
  assign q_pop    = q_valid && !(out_valid_r && out_stall);
  assign code_now = 32'(shift_r);

  always_comb begin
    phase_nxt      = phase_r;
    held_short_nxt = held_short_r;
    held_long_nxt  = held_long_r;
    emit           = 1'b0;
    push           = 1'b0;
    push_bit       = 1'b0;
    case (phase_r)
      PH_HEADER: begin
        if (!q_data.is_high && q_data.hdr_match) begin
          phase_nxt = PH_START;
        end
      end
      PH_START: begin
        if (q_data.is_high) begin
          phase_nxt = q_data.near_short ? PH_LOW : PH_HEADER;
        end
      end
      PH_LOW: begin
        if (q_data.is_high) begin
          phase_nxt = PH_HEADER;
        end else if (q_data.gap) begin
          phase_nxt = PH_START;
          emit      = (bits_r >= cfg.min_bits);
        end else begin
          held_short_nxt = q_data.near_short;
          held_long_nxt  = q_data.near_long;
          phase_nxt      = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (!q_data.is_high) begin
          phase_nxt = PH_HEADER;
        end else if (held_short_r && q_data.near_long) begin
          push      = 1'b1;
          push_bit  = 1'b1;
          phase_nxt = PH_LOW;
        end else if (held_long_r && q_data.near_short) begin
          push      = 1'b1;
          phase_nxt = PH_LOW;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  always_comb begin
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    if (phase_r == PH_START && q_data.is_high && q_data.near_short) begin
      shift_nxt = '0;
      bits_nxt  = '0;
    end else if (push) begin
      shift_nxt = {shift_r[CODE_BITS-2:0], push_bit};
      if (bits_r != 8'hFF) begin
        bits_nxt = bits_r + 8'd1;
      end
    end
  end

  always_comb begin
    if (q_pop && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      shift_r      <= '0;
      bits_r       <= '0;
      held_short_r <= 1'b0;
      held_long_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r      <= phase_nxt;
        shift_r      <= shift_nxt;
        bits_r       <= bits_nxt;
        held_short_r <= held_short_nxt;
        held_long_r  <= held_long_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      code_r   <= code_now;
      total_r  <= bits_r;
      button_r <= code_now[2:1] & pwcd_pkg::BUTTON_MASK;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_word   = code_r;
  assign out_bit_total   = total_r;
  assign out_button_bits = button_r;

endmodule

// ----- sv/pulse_width_code_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// pulse_width_code_decoder_unit
// Decodes pulse-width keyfob frames from a stream of level/duration pulses.
// ----------------------------------------------------------------------------
// One pulse is accepted per clock while in_stall is low. The front classifies
// each pulse against the programmed short, long and tolerance values in the
// cycle it is accepted and writes it to a two-entry queue; the back runs the
// frame state machine on one queued pulse per clock unless a result is held
// under out_stall, and loads a result into the output register. out_valid is
// registered when the back pops the frame-ending gap pulse after older queued
// pulses. Input stall rises only when the queue is full, which happens only
// once a result is held under out_stall. Configuration registers are written
// through the APB-style port and should change only while the block is idle.
module pulse_width_code_decoder_unit #(
  parameter int DURATION_BITS = pwcd_pkg::DURATION_BITS_DEF,
  parameter int CODE_BITS     = pwcd_pkg::CODE_BITS_DEF,
  parameter int QUEUE_DEPTH   = pwcd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_pulse_level,
  input  logic [DURATION_BITS-1:0]       in_pulse_us,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_code_word,
  output logic [7:0]                     out_bit_total,
  output logic [1:0]                     out_button_bits,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pwcd_pkg::ADDR_BITS-1:0] paddr,
  input  logic [pwcd_pkg::DATA_BITS-1:0] pwdata,
  output logic [pwcd_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);

  pwcd_pkg::pwcd_cfg_t cfg_r;
  pwcd_pkg::pwcd_cls_t cls;
  pwcd_pkg::pwcd_cls_t q_data;
  pwcd_pkg::pwcd_reg_t reg_sel;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = pwcd_pkg::pwcd_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_unit_us <= pwcd_pkg::SHORT_UNIT_RST;
      cfg_r.long_unit_us  <= pwcd_pkg::LONG_UNIT_RST;
      cfg_r.tolerance_us  <= pwcd_pkg::TOLERANCE_RST;
      cfg_r.min_bits      <= pwcd_pkg::MIN_BITS_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        pwcd_pkg::REG_SHORT_UNIT: cfg_r.short_unit_us <= pwdata[15:0];
        pwcd_pkg::REG_LONG_UNIT:  cfg_r.long_unit_us  <= pwdata[15:0];
        pwcd_pkg::REG_TOLERANCE:  cfg_r.tolerance_us  <= pwdata[15:0];
        pwcd_pkg::REG_MIN_BITS:   cfg_r.min_bits      <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pwcd_pkg::REG_SHORT_UNIT: prdata = 32'(cfg_r.short_unit_us);
      pwcd_pkg::REG_LONG_UNIT:  prdata = 32'(cfg_r.long_unit_us);
      pwcd_pkg::REG_TOLERANCE:  prdata = 32'(cfg_r.tolerance_us);
      pwcd_pkg::REG_MIN_BITS:   prdata = 32'(cfg_r.min_bits);
      default:                  prdata = '0;
    endcase
  end

  pwcd_front #(
    .DURATION_BITS(DURATION_BITS)
  ) u_front (
    .cfg        (cfg_r),
    .pulse_level(in_pulse_level),
    .pulse_us   (in_pulse_us),
    .cls        (cls)
  );

  pwcd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_valid),
    .wr_data (cls),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_valid(q_valid),
    .rd_data (q_data),
    .count   (q_count)
  );

  assign in_stall = q_full;

  pwcd_back #(
    .CODE_BITS(CODE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_word  (out_code_word),
    .out_bit_total  (out_bit_total),
    .out_button_bits(out_button_bits)
  );

  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // input only stalls when the queue is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (q_count == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH)))
    else $error("input stalled with room in queue");

  // a fresh result only follows a queued pulse being consumed
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop))
    else $error("result without consumed pulse");

  // back stays stalled while a result is held
  a_hold_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !q_pop)
    else $error("queue popped while result held");

endmodule
